// ===== src/lpm_pkg.sv =====
package lpm_pkg;

    localparam int ROUTE_ENTRIES     = 256;
    localparam int NEIGHBOUR_ENTRIES = 256;
    localparam int RT_IW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int NB_IW = (NEIGHBOUR_ENTRIES > 1) ? $clog2(NEIGHBOUR_ENTRIES) : 1;

    localparam logic [15:0] IPV4_TYPE  = 16'h0800;
    localparam logic [5:0]  MAX_PREFIX = 6'd32;

    localparam logic [1:0] ACT_DECIDE = 2'd0;
    localparam logic [1:0] ACT_ROUTE  = 2'd1;
    localparam logic [1:0] ACT_NBR    = 2'd2;

    localparam logic [1:0] V_PASS     = 2'd0;
    localparam logic [1:0] V_DROP     = 2'd1;
    localparam logic [1:0] V_REDIRECT = 2'd2;
    localparam logic [1:0] V_WRITE    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RSCAN,
        S_NSCAN
    } t_state;

    typedef struct packed {
        logic [1:0]  action;
        logic        frame_ok;
        logic [15:0] ether_type;
        logic [31:0] address;
        logic [5:0]  prefix_len;
        logic [7:0]  port_index;
        logic [31:0] hop_address;
        logic [47:0] mac_value;
        logic        entry_valid;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [7:0]  out_port;
        logic [47:0] new_dst_mac;
        logic [47:0] new_src_mac;
        logic        write_ok;
    } t_out_item;

    // token walking the route chain
    typedef struct packed {
        logic             vld;
        logic             lookup;   // 1: longest match, 0: exact key find
        logic [31:0]      key;
        logic [5:0]       plen;
        logic             hit;
        logic [RT_IW-1:0] hit_idx;
        logic [5:0]       best_plen;
        logic [7:0]       port;
        logic [31:0]      hop;
        logic [47:0]      mac;
        logic             free;
        logic [RT_IW-1:0] free_idx;
    } t_rt_tok;

    typedef struct packed {
        logic             vld;
        logic [31:0]      key;
        logic             hit;
        logic [NB_IW-1:0] hit_idx;
        logic [47:0]      mac;
        logic             free;
        logic [NB_IW-1:0] free_idx;
    } t_nb_tok;

    typedef struct packed {
        logic             en;
        logic             clr;
        logic [RT_IW-1:0] idx;
        logic [31:0]      prefix;
        logic [5:0]       plen;
        logic [7:0]       port;
        logic [31:0]      hop;
        logic [47:0]      mac;
    } t_rt_wr;

    typedef struct packed {
        logic             en;
        logic             clr;
        logic [NB_IW-1:0] idx;
        logic [31:0]      ip;
        logic [47:0]      mac;
    } t_nb_wr;

    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        prefix_mask = ~(32'hFFFF_FFFF >> len);
    endfunction

endpackage

// ===== src/lpm_route_cell.sv =====
module lpm_route_cell import lpm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [RT_IW-1:0] i_idx,
    input  t_rt_tok          i_tok,
    input  t_rt_wr           i_wr,
    output t_rt_tok          o_tok
);

    logic        r_valid;
    logic [31:0] r_prefix;
    logic [5:0]  r_plen;
    logic [7:0]  r_port;
    logic [31:0] r_hop;
    logic [47:0] r_mac;
    t_rt_tok     r_tok;
    t_rt_tok     n_tok;

    always_comb begin
        n_tok = i_tok;
        if (i_tok.lookup) begin
            if (r_valid && ((i_tok.key & prefix_mask(r_plen)) == r_prefix) &&
                (!i_tok.hit || r_plen > i_tok.best_plen)) begin
                n_tok.hit       = 1'b1;
                n_tok.hit_idx   = i_idx;
                n_tok.best_plen = r_plen;
                n_tok.port      = r_port;
                n_tok.hop       = r_hop;
                n_tok.mac       = r_mac;
            end
        end else begin
            if (r_valid && !i_tok.hit && r_prefix == i_tok.key && r_plen == i_tok.plen) begin
                n_tok.hit     = 1'b1;
                n_tok.hit_idx = i_idx;
            end
            if (!r_valid && !i_tok.free) begin
                n_tok.free     = 1'b1;
                n_tok.free_idx = i_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_wr.en && i_wr.idx == i_idx) begin
                r_valid <= !i_wr.clr;
            end
        end
        if (i_wr.en && !i_wr.clr && i_wr.idx == i_idx) begin
            r_prefix <= i_wr.prefix;
            r_plen   <= i_wr.plen;
            r_port   <= i_wr.port;
            r_hop    <= i_wr.hop;
            r_mac    <= i_wr.mac;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== src/lpm_nbr_cell.sv =====
module lpm_nbr_cell import lpm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [NB_IW-1:0] i_idx,
    input  t_nb_tok          i_tok,
    input  t_nb_wr           i_wr,
    output t_nb_tok          o_tok
);

    logic        r_valid;
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    t_nb_tok     r_tok;
    t_nb_tok     n_tok;

    always_comb begin
        n_tok = i_tok;
        if (r_valid && !i_tok.hit && r_ip == i_tok.key) begin
            n_tok.hit     = 1'b1;
            n_tok.hit_idx = i_idx;
            n_tok.mac     = r_mac;
        end
        if (!r_valid && !i_tok.free) begin
            n_tok.free     = 1'b1;
            n_tok.free_idx = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_wr.en && i_wr.idx == i_idx) begin
                r_valid <= !i_wr.clr;
            end
        end
        if (i_wr.en && !i_wr.clr && i_wr.idx == i_idx) begin
            r_ip  <= i_wr.ip;
            r_mac <= i_wr.mac;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== src/ipv4_lpm_forward_decision.sv =====
// Forwarding decision for one Ethernet/IPv4 header, plus route and neighbour
// table writes. An item is taken when start is high and busy is low; its single
// result appears on o_result with o_strobe for exactly one cycle and must be
// taken then, as the block cannot be held off. Each table is a chain of cells
// that a search token walks one entry per cycle. Non-IPv4 decisions, invalid
// prefix lengths and unused action codes answer without a table search; a
// route write or a decision ending after the route search walks the route
// chain; a neighbour write walks the neighbour chain; a decision that needs the
// next hop walks the route chain and then the neighbour chain. busy stays high until the result is
// shown, so a new item may start in the cycle of the strobe. Both tables are
// empty after reset with no clearing pass.
module ipv4_lpm_forward_decision import lpm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    t_state    r_state, n_state;
    t_in_item  r_item;
    t_out_item r_res, n_res;
    logic      r_strobe, n_strobe;
    logic [7:0]  r_port;
    logic [47:0] r_smac;
    logic        accept;

    t_rt_tok rt_tok [ROUTE_ENTRIES+1];
    t_nb_tok nb_tok [NEIGHBOUR_ENTRIES+1];
    t_rt_tok rt_head;
    t_nb_tok nb_head;
    t_rt_wr  rt_wr;
    t_nb_wr  nb_wr;
    t_rt_tok rt_end;
    t_nb_tok nb_end;
    logic    ipv4;

    assign accept    = start && (r_state == S_IDLE);
    assign busy      = (r_state != S_IDLE);
    assign rt_tok[0] = rt_head;
    assign nb_tok[0] = nb_head;
    assign rt_end    = rt_tok[ROUTE_ENTRIES];
    assign nb_end    = nb_tok[NEIGHBOUR_ENTRIES];
    assign ipv4      = i_item.frame_ok && i_item.ether_type == IPV4_TYPE;

    for (genvar g = 0; g < ROUTE_ENTRIES; g++) begin : g_rt
        lpm_route_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (RT_IW'(g)),
            .i_tok   (rt_tok[g]),
            .i_wr    (rt_wr),
            .o_tok   (rt_tok[g+1])
        );
    end

    for (genvar g = 0; g < NEIGHBOUR_ENTRIES; g++) begin : g_nb
        lpm_nbr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (NB_IW'(g)),
            .i_tok   (nb_tok[g]),
            .i_wr    (nb_wr),
            .o_tok   (nb_tok[g+1])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_item.action == ACT_ROUTE && i_item.prefix_len <= MAX_PREFIX) begin
                        n_state = S_RSCAN;
                    end else if (i_item.action == ACT_NBR) begin
                        n_state = S_NSCAN;
                    end else if (i_item.action == ACT_DECIDE && ipv4) begin
                        n_state = S_RSCAN;
                    end
                end
            end
            S_RSCAN: begin
                if (rt_end.vld) begin
                    if (r_item.action == ACT_DECIDE && rt_end.hit &&
                        rt_end.hop != r_item.address) begin
                        n_state = S_NSCAN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_NSCAN: begin
                if (nb_end.vld) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        rt_head  = '0;
        nb_head  = '0;
        rt_wr    = '0;
        nb_wr    = '0;
        n_res    = '0;
        n_strobe = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_item.action)
                        ACT_ROUTE: begin
                            if (i_item.prefix_len <= MAX_PREFIX) begin
                                rt_head.vld  = 1'b1;
                                rt_head.key  = i_item.address &
                                               prefix_mask(i_item.prefix_len);
                                rt_head.plen = i_item.prefix_len;
                            end else begin
                                n_res.verdict = V_WRITE;
                                n_strobe      = 1'b1;
                            end
                        end
                        ACT_NBR: begin
                            nb_head.vld = 1'b1;
                            nb_head.key = i_item.address;
                        end
                        ACT_DECIDE: begin
                            if (ipv4) begin
                                rt_head.vld    = 1'b1;
                                rt_head.lookup = 1'b1;
                                rt_head.key    = i_item.address;
                            end else begin
                                n_res.verdict = V_PASS;
                                n_strobe      = 1'b1;
                            end
                        end
                        default: begin
                            n_res.verdict = V_WRITE;
                            n_strobe      = 1'b1;
                        end
                    endcase
                end
            end
            S_RSCAN: begin
                if (rt_end.vld) begin
                    if (r_item.action == ACT_ROUTE) begin
                        n_strobe      = 1'b1;
                        n_res.verdict = V_WRITE;
                        rt_wr.prefix  = rt_end.key;
                        rt_wr.plen    = rt_end.plen;
                        rt_wr.port    = r_item.port_index;
                        rt_wr.hop     = r_item.hop_address;
                        rt_wr.mac     = r_item.mac_value;
                        if (!r_item.entry_valid) begin
                            rt_wr.en  = rt_end.hit;
                            rt_wr.clr = 1'b1;
                            rt_wr.idx = rt_end.hit_idx;
                        end else begin
                            rt_wr.en  = rt_end.hit || rt_end.free;
                            rt_wr.idx = rt_end.hit ? rt_end.hit_idx : rt_end.free_idx;
                        end
                        n_res.write_ok = rt_wr.en;
                    end else if (!rt_end.hit) begin
                        n_res.verdict = V_DROP;
                        n_strobe      = 1'b1;
                    end else if (rt_end.hop == r_item.address) begin
                        n_res.verdict = V_PASS;
                        n_strobe      = 1'b1;
                    end else begin
                        nb_head.vld = 1'b1;
                        nb_head.key = rt_end.hop;
                    end
                end
            end
            S_NSCAN: begin
                if (nb_end.vld) begin
                    n_strobe = 1'b1;
                    if (r_item.action == ACT_NBR) begin
                        n_res.verdict = V_WRITE;
                        nb_wr.ip      = r_item.address;
                        nb_wr.mac     = r_item.mac_value;
                        if (!r_item.entry_valid) begin
                            nb_wr.en  = nb_end.hit;
                            nb_wr.clr = 1'b1;
                            nb_wr.idx = nb_end.hit_idx;
                        end else begin
                            nb_wr.en  = nb_end.hit || nb_end.free;
                            nb_wr.idx = nb_end.hit ? nb_end.hit_idx : nb_end.free_idx;
                        end
                        n_res.write_ok = nb_wr.en;
                    end else if (nb_end.hit) begin
                        n_res.verdict     = V_REDIRECT;
                        n_res.out_port    = r_port;
                        n_res.new_dst_mac = nb_end.mac;
                        n_res.new_src_mac = r_smac;
                    end else begin
                        n_res.verdict = V_DROP;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        r_res <= n_res;
        if (accept) r_item <= i_item;
        if (r_state == S_RSCAN && rt_end.vld) begin
            r_port <= rt_end.port;
            r_smac <= rt_end.mac;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

endmodule

// ===== src/lpm_checker.sv =====
module lpm_checker import lpm_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_strobe,
    input t_out_item o_result
);

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while busy");

    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("search ended without result");

    a_rise_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> (!o_strobe && $past(start)))
        else $error("search started without a transfer or with a result");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.verdict != V_REDIRECT) |->
        (o_result.out_port == 8'd0 && o_result.new_dst_mac == 48'd0 &&
         o_result.new_src_mac == 48'd0))
        else $error("forwarding fields set without redirect");

    a_write_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.verdict != V_WRITE) |-> !o_result.write_ok)
        else $error("write_ok set on decision");

endmodule

bind ipv4_lpm_forward_decision lpm_checker u_lpm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// ===== tb/lpm_decision_checker.sv =====
module lpm_decision_checker import lpm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  logic      i_busy,
    input  t_in_item  i_item,
    input  logic      i_strobe,
    input  t_out_item i_result,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        valid;
        logic [31:0] prefix;
        logic [5:0]  plen;
        logic [7:0]  port;
        logic [31:0] hop;
        logic [47:0] src_mac;
    } t_route;

    typedef struct packed {
        logic        valid;
        logic [31:0] ip;
        logic [47:0] mac;
    } t_nbr;

    t_route    routes[ROUTE_ENTRIES];
    t_nbr      nbrs[NEIGHBOUR_ENTRIES];
    t_out_item verdict_q[$];
    int        fails;

    function automatic logic [31:0] mask_of(input logic [5:0] len);
        return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
    endfunction

    function automatic logic update_routes(input t_in_item it);
        logic [31:0] key;
        int          slot;
        if (it.prefix_len > MAX_PREFIX) return 1'b0;
        key  = it.address & mask_of(it.prefix_len);
        slot = -1;
        foreach (routes[i])
            if (slot < 0 && routes[i].valid && routes[i].prefix == key &&
                routes[i].plen == it.prefix_len) slot = i;
        if (!it.entry_valid) begin
            if (slot < 0) return 1'b0;
            routes[slot].valid = 1'b0;
            return 1'b1;
        end
        if (slot < 0)
            foreach (routes[i])
                if (slot < 0 && !routes[i].valid) slot = i;
        if (slot < 0) return 1'b0;
        routes[slot] = '{1'b1, key, it.prefix_len, it.port_index, it.hop_address,
                         it.mac_value};
        return 1'b1;
    endfunction

    function automatic int find_nbr(input logic [31:0] ip);
        foreach (nbrs[i])
            if (nbrs[i].valid && nbrs[i].ip == ip) return i;
        return -1;
    endfunction

    function automatic logic update_nbrs(input t_in_item it);
        int slot;
        slot = find_nbr(it.address);
        if (!it.entry_valid) begin
            if (slot < 0) return 1'b0;
            nbrs[slot].valid = 1'b0;
            return 1'b1;
        end
        if (slot < 0)
            foreach (nbrs[i])
                if (slot < 0 && !nbrs[i].valid) slot = i;
        if (slot < 0) return 1'b0;
        nbrs[slot] = '{1'b1, it.address, it.mac_value};
        return 1'b1;
    endfunction

    function automatic t_out_item forward_verdict(input t_in_item it);
        t_out_item r;
        int        best;
        int        n;
        r    = '0;
        best = -1;
        if (it.action != ACT_DECIDE) begin
            r.verdict = V_WRITE;
            if (it.action == ACT_ROUTE)    r.write_ok = update_routes(it);
            else if (it.action == ACT_NBR) r.write_ok = update_nbrs(it);
            return r;
        end
        r.verdict = V_PASS;
        if (!it.frame_ok || it.ether_type != IPV4_TYPE) return r;
        foreach (routes[i])
            if (routes[i].valid &&
                (it.address & mask_of(routes[i].plen)) == routes[i].prefix &&
                (best < 0 || routes[i].plen > routes[best].plen)) best = i;
        if (best < 0) begin
            r.verdict = V_DROP;
            return r;
        end
        if (routes[best].hop == it.address) return r;
        n = find_nbr(routes[best].hop);
        if (n < 0) begin
            r.verdict = V_DROP;
            return r;
        end
        r.verdict     = V_REDIRECT;
        r.out_port    = routes[best].port;
        r.new_dst_mac = nbrs[n].mac;
        r.new_src_mac = routes[best].src_mac;
        return r;
    endfunction

    initial begin
        fails = 0;
        foreach (routes[i]) routes[i] = '0;
        foreach (nbrs[i]) nbrs[i] = '0;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && i_strobe) begin
            if (verdict_q.size() == 0) begin
                $error("result with nothing expected: %p", i_result);
                fails++;
            end else begin
                want = verdict_q.pop_front();
                if (i_result.verdict !== want.verdict) begin
                    $error("verdict: expected %0d, got %0d", want.verdict, i_result.verdict);
                    fails++;
                end
                if (i_result.out_port !== want.out_port) begin
                    $error("out_port: expected %0d, got %0d", want.out_port,
                           i_result.out_port);
                    fails++;
                end
                if (i_result.new_dst_mac !== want.new_dst_mac) begin
                    $error("new_dst_mac: expected %h, got %h", want.new_dst_mac,
                           i_result.new_dst_mac);
                    fails++;
                end
                if (i_result.new_src_mac !== want.new_src_mac) begin
                    $error("new_src_mac: expected %h, got %h", want.new_src_mac,
                           i_result.new_src_mac);
                    fails++;
                end
                if (i_result.write_ok !== want.write_ok) begin
                    $error("write_ok: expected %0d, got %0d", want.write_ok,
                           i_result.write_ok);
                    fails++;
                end
            end
        end
        // an item may be taken in the same cycle as the previous strobe
        if (i_rst_n && i_start && i_busy === 1'b0)
            verdict_q.push_back(forward_verdict(i_item));
    end

    assign o_fail_count = fails;
    assign o_pending    = verdict_q.size();

endmodule

// ===== tb/ipv4_lpm_forward_decision_test.sv =====
module ipv4_lpm_forward_decision_test import lpm_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_item  i_item;
    logic      busy;
    logic      o_strobe;
    t_out_item o_result;
    int        fail_count;
    int        pending;

    logic [31:0] nets[4];
    logic [31:0] hops[6];
    logic [31:0] fill_keys[$];

    ipv4_lpm_forward_decision u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    lpm_decision_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [47:0] rand_mac();
        return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
    endfunction

    function automatic t_in_item mk(input logic [1:0] act, input logic fok,
                                    input logic [15:0] et, input logic [31:0] addr,
                                    input logic [5:0] plen, input logic [7:0] port,
                                    input logic [31:0] hop, input logic [47:0] mac,
                                    input logic ev);
        return '{act, fok, et, addr, plen, port, hop, mac, ev};
    endfunction

    function automatic t_in_item decision(input logic [31:0] dst);
        return mk(ACT_DECIDE, 1'b1, IPV4_TYPE, dst, 6'($urandom), 8'($urandom),
                  $urandom(), rand_mac(), 1'($urandom));
    endfunction

    function automatic t_in_item route_wr(input logic [31:0] pfx, input logic [5:0] plen,
                                          input logic [31:0] hop, input logic ev);
        return mk(ACT_ROUTE, 1'($urandom), 16'($urandom), pfx, plen, 8'($urandom),
                  hop, rand_mac(), ev);
    endfunction

    function automatic t_in_item nbr_wr(input logic [31:0] ip, input logic ev);
        return mk(ACT_NBR, 1'($urandom), 16'($urandom), ip, 6'($urandom), 8'($urandom),
                  $urandom(), rand_mac(), ev);
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send(input t_in_item it);
        int gap;
        logic taken;
        gap = $urandom_range(0, 13);
        repeat (gap) @(negedge i_clk);
        start  = 1'b1;
        i_item = it;
        taken  = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
        @(negedge i_clk);
        start = 1'b0;
    endtask

    function automatic logic [31:0] near(input logic [31:0] base);
        return base ^ ($urandom() & ((32'h1 << $urandom_range(0, 16)) - 1));
    endfunction

    initial begin
        int r;
        logic [5:0] plen;
        logic [31:0] a;
        start   = 1'b0;
        i_item  = '0;
        i_rst_n = 1'b0;
        foreach (nets[i]) nets[i] = $urandom();
        foreach (hops[i]) hops[i] = $urandom();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty tables, bad writes, then a small route set
        send(mk(ACT_DECIDE, 1'b0, IPV4_TYPE, 32'hFFFF_FFFF, 6'd0, 8'd0, 32'd0, 48'd0,
                1'b0));
        send(mk(ACT_DECIDE, 1'b1, 16'h86DD, nets[0], 6'd0, 8'd0, 32'd0, 48'd0, 1'b0));
        send(decision(32'h0));
        send(route_wr(nets[0], 6'd33, hops[0], 1'b1));
        send(route_wr(nets[0], 6'd63, hops[0], 1'b1));
        send(route_wr(nets[0], 6'd24, hops[0], 1'b0));
        send(nbr_wr(hops[0], 1'b0));
        send(mk(ACT_UNUSED, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 6'd63, 8'hFF, 32'hFFFF_FFFF,
                48'hFFFF_FFFF_FFFF, 1'b1));
        send(route_wr(32'hFFFF_FFFF, 6'd0, hops[1], 1'b1));
        send(route_wr(nets[1], 6'd32, nets[1], 1'b1));
        send(route_wr(nets[0], 6'd24, hops[0], 1'b1));
        send(nbr_wr(hops[0], 1'b1));
        send(decision(nets[0] ^ 32'hFF));
        send(decision(32'h0));
        send(decision(nets[1]));
        // same key with different bits past the mask replaces the entry
        send(mk(ACT_ROUTE, 1'b1, IPV4_TYPE, nets[0] ^ 32'h5A, 6'd24, 8'hFF, hops[0],
                48'hFFFF_FFFF_FFFF, 1'b1));
        send(decision(nets[0]));
        send(mk(ACT_NBR, 1'b0, 16'h0, hops[0], 6'd0, 8'd0, 32'd0, 48'hFFFF_FFFF_FFFF,
                1'b1));
        send(decision(nets[0]));
        send(route_wr(nets[0], 6'd24, 32'd0, 1'b0));
        send(decision(32'hFFFF_FFFF));

        // fill the neighbour table past capacity and remove those entries again, then do the same for the route table
        for (int i = 0; i <= NEIGHBOUR_ENTRIES; i++) begin
            a = $urandom();
            fill_keys.push_back(a);
            send(nbr_wr(a, 1'b1));
        end
        while (fill_keys.size() != 0) send(nbr_wr(fill_keys.pop_front(), 1'b0));
        for (int i = 0; i <= ROUTE_ENTRIES; i++) begin
            a = $urandom();
            fill_keys.push_back(a);
            send(route_wr(a, 6'd32, hops[$urandom_range(0, 5)], 1'b1));
        end
        send(decision(fill_keys[3]));
        while (fill_keys.size() != 0) send(route_wr(fill_keys.pop_front(), 6'd32, 32'd0, 1'b0));

        for (int n = 0; n < 250; n++) begin
            r = $urandom_range(0, 99);
            if (r < 38) begin
                case ($urandom_range(0, 3))
                    0, 1: a = near(nets[$urandom_range(0, 3)]);
                    2: a = hops[$urandom_range(0, 5)];
                    default: a = $urandom();
                endcase
                i_item = decision(a);
                if ($urandom_range(0, 9) == 0) i_item.frame_ok = 1'b0;
                if ($urandom_range(0, 9) == 0) i_item.ether_type = 16'($urandom);
                send(i_item);
            end else if (r < 65) begin
                case ($urandom_range(0, 7))
                    0: plen = 6'd0;
                    1: plen = 6'd32;
                    2: plen = 6'($urandom_range(33, 63));
                    default: plen = 6'($urandom_range(8, 30));
                endcase
                a = ($urandom_range(0, 5) == 0) ? $urandom() : hops[$urandom_range(0, 5)];
                send(route_wr(near(nets[$urandom_range(0, 3)]), plen, a,
                              $urandom_range(0, 99) < 85));
            end else if (r < 88) begin
                a = ($urandom_range(0, 7) == 0) ? $urandom() : hops[$urandom_range(0, 5)];
                send(nbr_wr(a, $urandom_range(0, 99) < 80));
            end else begin
                i_item = mk(ACT_UNUSED, 1'($urandom), 16'($urandom), $urandom(),
                            6'($urandom), 8'($urandom), $urandom(), rand_mac(),
                            1'($urandom));
                send(i_item);
            end
        end
        start = 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
